// File: hdl/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = PTR_W + 1;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned ST_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_INSERT     = 3'd5,
    OP_ERASE      = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_SHIFT = 2'd2
  } kind_e;

  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] value;
    logic [IDX_W-1:0]      index;
  } in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic [CNT_W-1:0]      count;
    stat_e                 status;
  } out_t;

  typedef struct packed {
    logic accept;
    logic rd_done;
    logic sh_rd;
    logic sh_wr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  more;
  } sts_t;

endpackage

// File: hdl/bdq_ram.sv
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/bdq_ctrl.sv
module bdq_ctrl import bdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_SHRD = 5'b00100,
    S_SHWR = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = accept;
        if (accept) begin
          if (sts_i.kind == KIND_READ) begin
            state_d = S_RD;
          end else if (sts_i.kind == KIND_SHIFT) begin
            state_d = S_SHRD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_done = 1'b1;
        state_d       = S_IDLE;
      end
      S_SHRD: begin
        cmd_o.sh_rd = 1'b1;
        state_d     = sts_i.more ? S_SHWR : S_FIN;
      end
      S_SHWR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = S_SHRD;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if ((accept && sts_i.kind == KIND_DONE) || cmd_o.rd_done || cmd_o.fin) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/bdq_dpath.sv
module bdq_dpath import bdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  function automatic logic [PTR_W-1:0] slot(logic [PTR_W-1:0] h, logic [CNT_W-1:0] p);
    return PTR_W'(h + p[PTR_W-1:0]);
  endfunction

  logic [PTR_W-1:0]      head_q, head_n;
  logic [CNT_W-1:0]      count_q, cnt_n, cnt_fin;
  logic [CNT_W-1:0]      pos_q, idx_q, idx9;
  logic                  is_ins_q;
  logic [DATA_WIDTH-1:0] val_q;
  out_t                  out_q;
  kind_e                 kind;
  stat_e                 st;
  logic                  full, empty, we_a, commit;
  logic [PTR_W-1:0]      waddr_a, src;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign idx9  = {1'b0, in_data_i.index};
  assign full  = count_q == CNT_W'(CAPACITY);
  assign empty = count_q == '0;

  always_comb begin
    kind    = KIND_DONE;
    st      = ST_OK;
    head_n  = head_q;
    cnt_n   = count_q;
    we_a    = 1'b0;
    waddr_a = slot(head_q, count_q);
    unique case (in_data_i.op)
      OP_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          we_a  = 1'b1;
          cnt_n = count_q + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          head_n  = head_q - PTR_W'(1);
          we_a    = 1'b1;
          waddr_a = head_n;
          cnt_n   = count_q + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          cnt_n = count_q - CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          head_n = head_q + PTR_W'(1);
          cnt_n  = count_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (idx9 >= count_q) begin
          st = ST_RANGE;
        end else begin
          kind = KIND_READ;
        end
      end
      OP_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if (idx9 > count_q) begin
          st = ST_RANGE;
        end else if (idx9 == count_q) begin
          we_a  = 1'b1;
          cnt_n = count_q + CNT_W'(1);
        end else begin
          kind = KIND_SHIFT;
        end
      end
      OP_ERASE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (idx9 >= count_q) begin
          st = ST_RANGE;
        end else if (idx9 + CNT_W'(1) == count_q) begin
          cnt_n = count_q - CNT_W'(1);
        end else begin
          kind = KIND_SHIFT;
        end
      end
      OP_CLEAR: begin
        head_n = '0;
        cnt_n  = '0;
      end
      default: kind = KIND_DONE;
    endcase
  end

  assign commit     = cmd_i.accept && kind == KIND_DONE;
  assign cnt_fin    = is_ins_q ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
  assign src        = is_ins_q ? slot(head_q, pos_q - CNT_W'(1))
                               : slot(head_q, pos_q + CNT_W'(1));
  assign sts_o.kind = kind;
  assign sts_o.more = is_ins_q ? (pos_q > idx_q) : ((pos_q + CNT_W'(1)) < count_q);

  assign ram_we    = (commit && we_a) || cmd_i.sh_wr || (cmd_i.fin && is_ins_q);
  assign ram_waddr = cmd_i.sh_wr ? slot(head_q, pos_q) :
                     cmd_i.fin   ? slot(head_q, idx_q) : waddr_a;
  assign ram_wdata = cmd_i.sh_wr ? ram_rdata : cmd_i.fin ? val_q : in_data_i.value;
  assign ram_raddr = cmd_i.sh_rd ? src : slot(head_q, idx9);

  bdq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (commit) begin
      head_q  <= head_n;
      count_q <= cnt_n;
    end else if (cmd_i.fin) begin
      count_q <= cnt_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      is_ins_q <= in_data_i.op == OP_INSERT;
      pos_q    <= (in_data_i.op == OP_INSERT) ? count_q : idx9;
      idx_q    <= idx9;
      val_q    <= in_data_i.value;
    end else if (cmd_i.sh_wr) begin
      pos_q <= is_ins_q ? pos_q - CNT_W'(1) : pos_q + CNT_W'(1);
    end
    if (commit) begin
      out_q.read_data <= '0;
      out_q.count     <= cnt_n;
      out_q.status    <= st;
    end else if (cmd_i.rd_done) begin
      out_q.read_data <= ram_rdata;
      out_q.count     <= count_q;
      out_q.status    <= ST_OK;
    end else if (cmd_i.fin) begin
      out_q.read_data <= '0;
      out_q.count     <= cnt_fin;
      out_q.status    <= ST_OK;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: hdl/bounded_deque_engine_unit.sv
// Bounded double-ended queue of 256 words held in a circular RAM.
// The input channel carries one command per transaction (push or pop at
// either end, read, insert or erase at a position from the front, clear);
// the output channel returns exactly one result per command: the element
// read, the element count after the command and a status code.
// Pushes, pops, clear, every rejected command, insert at the back end and
// erase of the last element complete in the accepting cycle: the result is
// registered at the edge that accepts the command, and such commands run one
// per cycle while the receiver does not stall. A read adds a state (S_RD)
// because of the registered RAM read port. Insert and erase that move
// elements pass through the accepting cycle, a read and a write state per
// element moved on the single RAM, then a last read and a finishing state.
// Only one command is in flight; the input stalls until the result of a
// multi-cycle command is registered.
// When the receiver stalls, the result holds in the output register and a new
// command is accepted only once that result is taken.
// Reset empties the queue (count and head pointer return to zero) and drops
// any result not yet taken; RAM contents are left as they are.
module bounded_deque_engine_unit import bdq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdq_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.rd_done, cmd.sh_rd, cmd.sh_wr, cmd.fin}))
    else $error("more than one datapath command at once");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_done || cmd.sh_rd || cmd.sh_wr || cmd.fin) |-> !out_valid_o)
    else $error("output register occupied during a multi-cycle command");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.count <= CNT_W'(CAPACITY)))
    else $error("count exceeds capacity");

  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> (out_data_o.read_data == '0))
    else $error("nonzero read data on a failed command");
`endif

endmodule

// File: dv/tb_bounded_deque_engine_unit.sv
module tb_bounded_deque_engine_unit;
  import bdq_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 355;
  localparam int unsigned EDGE_VISITS      = 12;
  localparam int unsigned MIXED_STRETCH    = 60;
  localparam int unsigned SETTLE_CYCLES    = 600;
  localparam int unsigned DUE_DEPTH        = 4;

  typedef enum {LEAN_GROW, LEAN_SHRINK, LEAN_MIXED} lean_e;

  class deque_tracker;
    logic [DATA_WIDTH-1:0] mirror_slots [CAPACITY];
    logic [PTR_W-1:0]      mirror_head;
    logic [CNT_W-1:0]      mirror_count;
    out_t                  replies_due [DUE_DEPTH];
    int unsigned           due_rd;
    int unsigned           due_wr;
    int unsigned           due_count;
    int unsigned           mismatches;
    int unsigned           commands_seen;
    int unsigned           status_hits [4];
    int unsigned           peak_count;

    function new();
      mirror_head   = '0;
      mirror_count  = '0;
      due_rd        = 0;
      due_wr        = 0;
      due_count     = 0;
      mismatches    = 0;
      commands_seen = 0;
      peak_count    = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function logic [PTR_W-1:0] slot_at(int unsigned pos);
      return PTR_W'((mirror_head + pos) % CAPACITY);
    endfunction

    function void apply_command(in_t cmd);
      out_t        reply;
      int unsigned pos;
      reply.read_data = '0;
      reply.status    = ST_OK;
      case (cmd.op)
        OP_PUSH_BACK: begin
          if (mirror_count == CAPACITY) begin
            reply.status = ST_FULL;
          end else begin
            mirror_slots[slot_at(32'(mirror_count))] = cmd.value;
            mirror_count++;
          end
        end
        OP_PUSH_FRONT: begin
          if (mirror_count == CAPACITY) begin
            reply.status = ST_FULL;
          end else begin
            mirror_head = PTR_W'((mirror_head + CAPACITY - 1) % CAPACITY);
            mirror_slots[mirror_head] = cmd.value;
            mirror_count++;
          end
        end
        OP_POP_BACK: begin
          if (mirror_count == 0) begin
            reply.status = ST_EMPTY;
          end else begin
            mirror_count--;
          end
        end
        OP_POP_FRONT: begin
          if (mirror_count == 0) begin
            reply.status = ST_EMPTY;
          end else begin
            mirror_head = slot_at(1);
            mirror_count--;
          end
        end
        OP_READ: begin
          if (cmd.index >= mirror_count) begin
            reply.status = ST_RANGE;
          end else begin
            reply.read_data = mirror_slots[slot_at(32'(cmd.index))];
          end
        end
        OP_INSERT: begin
          if (mirror_count == CAPACITY) begin
            reply.status = ST_FULL;
          end else if (cmd.index > mirror_count) begin
            reply.status = ST_RANGE;
          end else begin
            for (pos = 32'(mirror_count); pos > cmd.index; pos--) begin
              mirror_slots[slot_at(pos)] = mirror_slots[slot_at(pos - 1)];
            end
            mirror_slots[slot_at(32'(cmd.index))] = cmd.value;
            mirror_count++;
          end
        end
        OP_ERASE: begin
          if (mirror_count == 0) begin
            reply.status = ST_EMPTY;
          end else if (cmd.index >= mirror_count) begin
            reply.status = ST_RANGE;
          end else begin
            for (pos = 32'(cmd.index); pos + 1 < mirror_count; pos++) begin
              mirror_slots[slot_at(pos)] = mirror_slots[slot_at(pos + 1)];
            end
            mirror_count--;
          end
        end
        OP_CLEAR: begin
          mirror_head  = '0;
          mirror_count = '0;
        end
      endcase
      reply.count = mirror_count;
      commands_seen++;
      status_hits[reply.status]++;
      if (mirror_count > peak_count) peak_count = 32'(mirror_count);
      if (due_count == DUE_DEPTH) begin
        $error("More results expected than the scoreboard can hold.");
        mismatches++;
      end else begin
        replies_due[due_wr] = reply;
        due_wr              = (due_wr + 1) % DUE_DEPTH;
        due_count++;
      end
    endfunction

    function void compare_reply(out_t got);
      out_t want;
      if (due_count == 0) begin
        $error("Result %p arrived with no command outstanding.", got);
        mismatches++;
        return;
      end
      want   = replies_due[due_rd];
      due_rd = (due_rd + 1) % DUE_DEPTH;
      due_count--;
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_stall_o;
  in_t          in_data_i;
  logic         out_valid_o;
  logic         out_stall_i;
  out_t         out_data_o;
  int unsigned  idle_pct;
  int unsigned  stall_pct;
  deque_tracker tracker;

  bounded_deque_engine_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.compare_reply(out_data_o);
    end
  end

  function automatic in_t make_cmd(op_e op, logic [DATA_WIDTH-1:0] value,
                                   logic [IDX_W-1:0] index);
    in_t cmd;
    cmd.op    = op;
    cmd.value = value;
    cmd.index = index;
    return cmd;
  endfunction

  function automatic in_t random_command(lean_e lean);
    in_t         cmd;
    int unsigned lvl;
    int unsigned roll;
    int unsigned top;
    lvl  = 32'(tracker.mirror_count);
    roll = $urandom_range(99);
    case (lean)
      LEAN_GROW: begin
        if (roll < 40) cmd.op = OP_PUSH_BACK;
        else if (roll < 68) cmd.op = OP_PUSH_FRONT;
        else if (roll < 88) cmd.op = OP_INSERT;
        else if (roll < 95) cmd.op = OP_READ;
        else if (roll < 97) cmd.op = OP_POP_FRONT;
        else cmd.op = OP_ERASE;
      end
      LEAN_SHRINK: begin
        if (roll < 30) cmd.op = OP_POP_BACK;
        else if (roll < 58) cmd.op = OP_POP_FRONT;
        else if (roll < 82) cmd.op = OP_ERASE;
        else if (roll < 95) cmd.op = OP_READ;
        else cmd.op = OP_INSERT;
      end
      default: begin
        if (roll < 3) cmd.op = OP_CLEAR;
        else cmd.op = op_e'($urandom_range(6));
      end
    endcase
    case ($urandom_range(19))
      0: cmd.value = '0;
      1: cmd.value = '1;
      default: cmd.value = $urandom();
    endcase
    roll = $urandom_range(99);
    if (roll < 80) begin
      if (cmd.op == OP_INSERT) begin
        top = (lvl > 255) ? 255 : lvl;
        cmd.index = IDX_W'($urandom_range(top, 0));
      end else if (lvl != 0) begin
        cmd.index = IDX_W'($urandom_range(lvl - 1, 0));
      end else begin
        cmd.index = IDX_W'($urandom_range(255));
      end
    end else if (roll < 90) begin
      cmd.index = IDX_W'($urandom_range(255));
    end else begin
      case ($urandom_range(2))
        0: cmd.index = '0;
        1: cmd.index = '1;
        default: cmd.index = IDX_W'(lvl);
      endcase
    end
    return cmd;
  endfunction

  task automatic send_item(in_t cmd);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.apply_command(cmd);
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.due_count != 0) @(posedge clk_i);
  endtask

  initial begin
    #100_000_000;
    $error("Timeout with %0d results outstanding.", tracker.due_count);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    lean_e       lean;
    int unsigned edge_hits;
    int unsigned mixed_left;
    tracker     = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_cmd(OP_POP_BACK, '0, '0));
    send_item(make_cmd(OP_POP_FRONT, '1, '1));
    send_item(make_cmd(OP_ERASE, 32'h0000_0001, 8'd0));
    send_item(make_cmd(OP_READ, '0, 8'd0));
    send_item(make_cmd(OP_INSERT, 32'h1234_5678, 8'd1));
    send_item(make_cmd(OP_INSERT, '1, 8'd0));
    send_item(make_cmd(OP_PUSH_FRONT, '0, 8'h55));
    send_item(make_cmd(OP_PUSH_BACK, 32'hA5A5_A5A5, 8'hAA));
    send_item(make_cmd(OP_PUSH_FRONT, 32'h5A5A_5A5A, 8'd0));
    send_item(make_cmd(OP_INSERT, 32'hDEAD_BEEF, 8'd2));
    send_item(make_cmd(OP_READ, '0, 8'd0));
    send_item(make_cmd(OP_READ, '0, 8'd4));
    send_item(make_cmd(OP_READ, '0, 8'hFF));
    send_item(make_cmd(OP_READ, '0, 8'd5));
    send_item(make_cmd(OP_ERASE, '0, 8'd1));
    send_item(make_cmd(OP_ERASE, '0, 8'd3));
    send_item(make_cmd(OP_ERASE, '0, 8'hFF));
    send_item(make_cmd(OP_INSERT, 32'h3C3C_3C3C, 8'hFF));
    send_item(make_cmd(OP_INSERT, 32'h0F0F_0F0F, 8'd3));
    send_item(make_cmd(OP_POP_BACK, '0, '0));
    send_item(make_cmd(OP_POP_FRONT, '0, '0));
    send_item(make_cmd(OP_READ, '0, 8'd1));
    send_item(make_cmd(OP_CLEAR, '1, '1));
    send_item(make_cmd(OP_READ, '0, 8'd0));
    send_item(make_cmd(OP_PUSH_BACK, 32'h0000_0001, 8'd0));
    drain_replies();

    lean       = LEAN_GROW;
    edge_hits  = 0;
    mixed_left = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 21;
          stall_pct = 21;
        end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        case (lean)
          LEAN_GROW: begin
            if (tracker.mirror_count == CAPACITY) begin
              edge_hits++;
              if (edge_hits > EDGE_VISITS) begin
                lean      = LEAN_SHRINK;
                edge_hits = 0;
              end
            end
          end
          LEAN_SHRINK: begin
            if (tracker.mirror_count == 0) begin
              edge_hits++;
              if (edge_hits > EDGE_VISITS) begin
                lean       = LEAN_MIXED;
                edge_hits  = 0;
                mixed_left = MIXED_STRETCH;
              end
            end
          end
          default: begin
            if (mixed_left == 0) lean = LEAN_GROW;
            else mixed_left--;
          end
        endcase
        send_item(random_command(lean));
      end
      drain_replies();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d commands under four traffic patterns; peak depth %0d of %0d.",
             tracker.commands_seen, tracker.peak_count, CAPACITY);
    $display("Status counts: ok %0d, full %0d, empty %0d, out of range %0d.",
             tracker.status_hits[ST_OK], tracker.status_hits[ST_FULL],
             tracker.status_hits[ST_EMPTY], tracker.status_hits[ST_RANGE]);
    if (tracker.mismatches == 0 && tracker.due_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
